// ===== rtl/letter_union_find_equivalence_defines.svh =====
// Assertion macros for the letter union-find equivalence block.
`ifndef LETTER_UNION_FIND_EQUIVALENCE_DEFINES_SVH
`define LETTER_UNION_FIND_EQUIVALENCE_DEFINES_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define LUFE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define LUFE_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define LUFE_ASSERT(label, prop, msg)
`define LUFE_NEVER(label, cond, msg)
`endif

`endif

// ===== rtl/lufe_pkg.sv =====
// Shared types and constants for the letter union-find equivalence block.
package lufe_pkg;

  // Letter index width on the ports and on internal links
  localparam int unsigned LW = 5;
  // Set size width and saturation value
  localparam int unsigned SIZE_W = 5;
  localparam logic [SIZE_W-1:0] SIZE_MAX = 5'd31;

  // Transaction kinds; code 3 is unused and ignored
  typedef enum logic [1:0] {
    ACT_UNITE    = 2'd0,
    ACT_QUERY    = 2'd1,
    ACT_MISMATCH = 2'd2
  } act_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_COMPRESS,
    ST_SIZE_RD,
    ST_MERGE
  } state_t;

  // Request from the sequencer to the link/size store
  typedef struct packed {
    logic [LW-1:0]     par_raddr;
    logic              par_we;
    logic [LW-1:0]     par_waddr;
    logic [LW-1:0]     par_wdata;
    logic [LW-1:0]     size_raddr;
    logic              size_we;
    logic [LW-1:0]     size_waddr;
    logic [SIZE_W-1:0] size_wdata;
  } store_req_t;

endpackage

// ===== rtl/lufe_store.sv =====
// Parent-link and set-size register files, one read and one write port each.
module lufe_store #(
  parameter int unsigned ALPHABET = 26
) (
  input  logic                            clk,
  input  logic                            rst,
  input  lufe_pkg::store_req_t            req,
  output logic [lufe_pkg::LW-1:0]         par_rdata,
  output logic [lufe_pkg::SIZE_W-1:0]     size_rdata
);

  localparam int unsigned IW = $clog2(ALPHABET);

  logic [IW-1:0]               parent [ALPHABET];
  logic [lufe_pkg::SIZE_W-1:0] size   [ALPHABET];

  // Reset makes every letter its own singleton set
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ALPHABET; i++) begin
        parent[i] <= IW'(i);
        size[i]   <= lufe_pkg::SIZE_W'(1);
      end
    end else begin
      if (req.par_we) begin
        parent[req.par_waddr[IW-1:0]] <= req.par_wdata[IW-1:0];
      end
      if (req.size_we) begin
        size[req.size_waddr[IW-1:0]] <= req.size_wdata;
      end
    end
  end

  // Combinational read ports
  assign par_rdata  = lufe_pkg::LW'(parent[req.par_raddr[IW-1:0]]);
  assign size_rdata = size[req.size_raddr[IW-1:0]];

endmodule

// ===== rtl/lufe_ctrl.sv =====
// Sequencer: root walk, path compression, union by size and match flag.
module lufe_ctrl #(
  parameter int unsigned ALPHABET = 26
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [1:0]                  action,
  input  logic [lufe_pkg::LW-1:0]     letter_a,
  input  logic [lufe_pkg::LW-1:0]     letter_b,
  input  logic                        skip,
  input  logic                        last,
  input  logic [lufe_pkg::LW-1:0]     par_rdata,
  input  logic [lufe_pkg::SIZE_W-1:0] size_rdata,
  output lufe_pkg::store_req_t        req,
  output logic                        busy,
  output logic                        answer,
  output logic                        done
);

  localparam int unsigned LW = lufe_pkg::LW;
  localparam int unsigned SW = lufe_pkg::SIZE_W;

  lufe_pkg::state_t state, state_next;
  lufe_pkg::act_t   act_in;

  logic          accept;
  logic          in_range;
  logic          walk;
  logic          flag, flag_next;
  logic          emit, emit_val;
  logic          op_unite, last_q, which;
  logic [LW-1:0] cur, node, ra, rb, b_q, root_sel;
  logic [SW-1:0] size_a;
  logic [SW:0]   size_sum;
  logic [SW-1:0] size_sat;
  logic          at_root, node_done;

  assign act_in    = lufe_pkg::act_t'(action);
  assign busy      = (state != lufe_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign in_range  = ({1'b0, letter_a} < (LW + 1)'(ALPHABET)) &&
                     ({1'b0, letter_b} < (LW + 1)'(ALPHABET));
  // Item needs the tree walk
  assign walk      = !skip && in_range &&
                     (act_in == lufe_pkg::ACT_UNITE || act_in == lufe_pkg::ACT_QUERY);
  assign root_sel  = which ? rb : ra;
  // Compare units: link equals self during find; node reached root in compression
  assign at_root   = (par_rdata == cur);
  assign node_done = (node == root_sel);
  assign size_sum  = {1'b0, size_a} + {1'b0, size_rdata};
  assign size_sat  = (size_sum > (SW + 1)'(lufe_pkg::SIZE_MAX)) ? lufe_pkg::SIZE_MAX
                                                                 : size_sum[SW-1:0];

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      lufe_pkg::ST_IDLE: begin
        if (accept && walk) state_next = lufe_pkg::ST_FIND;
      end
      lufe_pkg::ST_FIND: begin
        if (at_root) state_next = lufe_pkg::ST_COMPRESS;
      end
      lufe_pkg::ST_COMPRESS: begin
        if (node_done) begin
          if (!which) state_next = lufe_pkg::ST_FIND;
          else if (op_unite && (ra != rb)) state_next = lufe_pkg::ST_SIZE_RD;
          else state_next = lufe_pkg::ST_IDLE;
        end
      end
      lufe_pkg::ST_SIZE_RD: state_next = lufe_pkg::ST_MERGE;
      lufe_pkg::ST_MERGE:   state_next = lufe_pkg::ST_IDLE;
      default:              state_next = lufe_pkg::ST_IDLE;
    endcase
  end

  // Store requests, result and match flag
  always_comb begin
    req       = '0;
    emit      = 1'b0;
    emit_val  = 1'b0;
    flag_next = flag;
    unique case (state)
      lufe_pkg::ST_IDLE: begin
        if (accept && !walk) begin
          unique case (act_in)
            lufe_pkg::ACT_QUERY: begin
              if (last) begin
                emit      = 1'b1;
                emit_val  = flag && (skip || in_range);
                flag_next = 1'b1;
              end else begin
                flag_next = flag && (skip || in_range);
              end
            end
            lufe_pkg::ACT_MISMATCH: begin
              emit      = 1'b1;
              emit_val  = 1'b0;
              flag_next = 1'b1;
            end
            default: ;
          endcase
        end
      end
      lufe_pkg::ST_FIND: begin
        req.par_raddr = cur;
      end
      lufe_pkg::ST_COMPRESS: begin
        req.par_raddr = node;
        if (!node_done) begin
          req.par_we    = 1'b1;
          req.par_waddr = node;
          req.par_wdata = root_sel;
        end else if (which && !op_unite) begin
          if (last_q) begin
            emit      = 1'b1;
            emit_val  = flag && (ra == rb);
            flag_next = 1'b1;
          end else begin
            flag_next = flag && (ra == rb);
          end
        end
      end
      lufe_pkg::ST_SIZE_RD: begin
        req.size_raddr = ra;
      end
      lufe_pkg::ST_MERGE: begin
        req.size_raddr = rb;
        req.par_we     = 1'b1;
        req.size_we    = 1'b1;
        req.size_wdata = size_sat;
        if (size_a < size_rdata) begin
          req.par_waddr  = ra;
          req.par_wdata  = rb;
          req.size_waddr = rb;
        end else begin
          req.par_waddr  = rb;
          req.par_wdata  = ra;
          req.size_waddr = ra;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lufe_pkg::ST_IDLE;
      flag  <= 1'b1;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      flag  <= flag_next;
      done  <= emit;
    end
  end

  // Walk pointers and captured operands
  always_ff @(posedge clk) begin
    answer <= emit_val;
    unique case (state)
      lufe_pkg::ST_IDLE: begin
        if (accept) begin
          op_unite <= (act_in == lufe_pkg::ACT_UNITE);
          last_q   <= last;
          which    <= 1'b0;
          cur      <= letter_a;
          node     <= letter_a;
          b_q      <= letter_b;
        end
      end
      lufe_pkg::ST_FIND: begin
        if (at_root) begin
          if (which) rb <= cur;
          else ra <= cur;
        end else begin
          cur <= par_rdata;
        end
      end
      lufe_pkg::ST_COMPRESS: begin
        if (!node_done) begin
          node <= par_rdata;
        end else if (!which) begin
          which <= 1'b1;
          cur   <= b_q;
          node  <= b_q;
        end
      end
      lufe_pkg::ST_SIZE_RD: size_a <= size_rdata;
      default: ;
    endcase
  end

endmodule

// ===== rtl/letter_union_find_equivalence.sv =====
// Top level of the letter union-find equivalence engine.
//
// Usage: drive action, letter_a, letter_b, skip and last with start high; the
// transaction is taken at a clock edge where start is high and busy is low.
// Action 0 unites the sets of two letters (union by size, path compression),
// action 1 feeds one letter pair of a query, action 2 reports a length mismatch.
// A query answer appears on answer for exactly one cycle with done high; the
// receiver cannot stall it, and the block never stalls on the output side.
// Sequence: find walks one parent link per cycle until it reads a root, then
// compression rewrites one path node per cycle until it reaches the root; this
// runs for letter_a then letter_b. A unite of two distinct roots adds a size
// read and a merge step. Union by size keeps every tree within four links;
// the single parent-link read port sets the pace. Skipped, out-of-range and
// mismatch transactions finish in the accept cycle, with any answer on the
// following cycle. busy is high while an item is worked on; one item at a
// time.
// Reset (synchronous, rst high) makes every letter its own set of size one and
// arms the match flag; no clearing pass is needed.
`include "letter_union_find_equivalence_defines.svh"

module letter_union_find_equivalence #(
  parameter int unsigned ALPHABET = 26
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              action,
  input  logic [lufe_pkg::LW-1:0] letter_a,
  input  logic [lufe_pkg::LW-1:0] letter_b,
  input  logic                    skip,
  input  logic                    last,
  output logic                    answer,
  output logic                    done
);

  lufe_pkg::store_req_t            req;
  logic [lufe_pkg::LW-1:0]         par_rdata;
  logic [lufe_pkg::SIZE_W-1:0]     size_rdata;

  // Sequencer
  lufe_ctrl #(.ALPHABET(ALPHABET)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .action     (action),
    .letter_a   (letter_a),
    .letter_b   (letter_b),
    .skip       (skip),
    .last       (last),
    .par_rdata  (par_rdata),
    .size_rdata (size_rdata),
    .req        (req),
    .busy       (busy),
    .answer     (answer),
    .done       (done)
  );

  // Link and size storage
  lufe_store #(.ALPHABET(ALPHABET)) u_store (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .par_rdata  (par_rdata),
    .size_rdata (size_rdata)
  );

  // A result always ends an item: the engine is free when it is reported
  `LUFE_NEVER(a_done_busy, done && busy, "result reported while still busy")
  // A result follows either work in progress or a freshly taken transaction
  `LUFE_ASSERT(a_done_cause, done |-> $past(busy || start), "result without a transaction")
  // Store is written only while an item is being worked on
  `LUFE_NEVER(a_idle_write, !busy && (req.par_we || req.size_we), "store write while idle")

endmodule

// ===== tb/letter_union_find_equivalence_tb.sv =====
// Testbench for the letter union-find equivalence engine: directed table, then random traffic.
module letter_union_find_equivalence_tb;

  localparam int unsigned LETTERS = 26;
  localparam int RANDOM_ITEMS = 1500;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_AT = 700;
  // Code 3 has no name in the package; the block ignores it
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] action = lufe_pkg::ACT_UNITE;
  logic [lufe_pkg::LW-1:0] letter_a = '0;
  logic [lufe_pkg::LW-1:0] letter_b = '0;
  logic skip = 1'b0;
  logic last = 1'b0;
  logic answer;
  logic done;

  letter_union_find_equivalence #(.ALPHABET(LETTERS)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .letter_a(letter_a), .letter_b(letter_b), .skip(skip), .last(last),
    .answer(answer), .done(done)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Directed stimulus; typed marks rows whose answer is written in by hand
  typedef struct packed {
    logic [1:0] act;
    logic [lufe_pkg::LW-1:0] a;
    logic [lufe_pkg::LW-1:0] b;
    logic sk;
    logic ls;
    bit typed;
    bit ans;
  } row_t;

  localparam int NUM_ROWS = 24;
  localparam row_t DIR_ROWS [NUM_ROWS] = '{
    '{lufe_pkg::ACT_QUERY,    5'd0,  5'd0,  1'b0, 1'b1, 1'b1, 1'b1}, // same letter after reset
    '{lufe_pkg::ACT_QUERY,    5'd0,  5'd25, 1'b0, 1'b1, 1'b1, 1'b0}, // two singletons
    '{lufe_pkg::ACT_MISMATCH, 5'd0,  5'd0,  1'b0, 1'b0, 1'b1, 1'b0},
    '{lufe_pkg::ACT_UNITE,    5'd0,  5'd25, 1'b0, 1'b0, 1'b0, 1'b0}, // extreme letters
    '{lufe_pkg::ACT_QUERY,    5'd25, 5'd0,  1'b0, 1'b1, 1'b0, 1'b0},
    '{lufe_pkg::ACT_UNITE,    5'd31, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0}, // out of range, ignored
    '{lufe_pkg::ACT_UNITE,    5'd1,  5'd2,  1'b1, 1'b0, 1'b0, 1'b0}, // skipped unite
    '{lufe_pkg::ACT_QUERY,    5'd1,  5'd2,  1'b0, 1'b1, 1'b0, 1'b0},
    '{lufe_pkg::ACT_QUERY,    5'd31, 5'd31, 1'b0, 1'b1, 1'b1, 1'b0}, // out-of-range pair
    '{lufe_pkg::ACT_QUERY,    5'd3,  5'd4,  1'b1, 1'b1, 1'b1, 1'b1}, // skipped last pair
    '{lufe_pkg::ACT_QUERY,    5'd0,  5'd25, 1'b0, 1'b0, 1'b0, 1'b0},
    '{lufe_pkg::ACT_QUERY,    5'd5,  5'd6,  1'b0, 1'b0, 1'b0, 1'b0},
    '{lufe_pkg::ACT_MISMATCH, 5'd0,  5'd0,  1'b0, 1'b1, 1'b1, 1'b0}, // drops partial query
    '{lufe_pkg::ACT_QUERY,    5'd0,  5'd0,  1'b0, 1'b1, 1'b1, 1'b1}, // flag rearmed
    '{ACT_UNUSED,             5'd7,  5'd9,  1'b0, 1'b1, 1'b0, 1'b0}, // ignored code
    '{lufe_pkg::ACT_UNITE,    5'd2,  5'd3,  1'b0, 1'b1, 1'b0, 1'b0}, // last outside query
    '{lufe_pkg::ACT_UNITE,    5'd4,  5'd5,  1'b0, 1'b0, 1'b0, 1'b0},
    '{lufe_pkg::ACT_UNITE,    5'd2,  5'd4,  1'b0, 1'b0, 1'b0, 1'b0}, // equal sizes
    '{lufe_pkg::ACT_UNITE,    5'd6,  5'd2,  1'b0, 1'b0, 1'b0, 1'b0}, // small joins large
    '{lufe_pkg::ACT_QUERY,    5'd3,  5'd5,  1'b0, 1'b0, 1'b0, 1'b0},
    '{lufe_pkg::ACT_QUERY,    5'd6,  5'd2,  1'b0, 1'b1, 1'b0, 1'b0},
    '{lufe_pkg::ACT_QUERY,    5'd5,  5'd30, 1'b1, 1'b1, 1'b1, 1'b1}, // skip hides bad letter
    '{lufe_pkg::ACT_QUERY,    5'd31, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0},
    '{lufe_pkg::ACT_QUERY,    5'd25, 5'd25, 1'b0, 1'b1, 1'b1, 1'b0}  // earlier bad pair
  };

  // Shadow of the letter classes
  logic [lufe_pkg::LW-1:0] link_of [LETTERS];
  logic [lufe_pkg::SIZE_W-1:0] class_size [LETTERS];
  bit pairs_agree;

  bit answers_due [$];
  int mismatches = 0;
  int items_sent = 0;
  int unites_sent = 0;
  int yes_due = 0;
  int no_due = 0;
  int noise_sent = 0;

  function automatic void clear_sets();
    for (int i = 0; i < LETTERS; i++) begin
      link_of[i] = i[lufe_pkg::LW-1:0];
      class_size[i] = lufe_pkg::SIZE_W'(1);
    end
    pairs_agree = 1'b1;
  endfunction

  // Root lookup that also flattens the walked path
  function automatic logic [lufe_pkg::LW-1:0] find_root(input logic [lufe_pkg::LW-1:0] x);
    logic [lufe_pkg::LW-1:0] r;
    logic [lufe_pkg::LW-1:0] nxt;
    r = x;
    for (int n = 0; n < LETTERS; n++) begin
      if (link_of[r] == r) break;
      r = link_of[r];
    end
    for (int n = 0; n < LETTERS && x != r; n++) begin
      nxt = link_of[x];
      link_of[x] = r;
      x = nxt;
    end
    return r;
  endfunction

  // Union by size; on a tie the first root stays
  function automatic void merge_sets(input logic [lufe_pkg::LW-1:0] a,
                                     input logic [lufe_pkg::LW-1:0] b);
    logic [lufe_pkg::LW-1:0] ra;
    logic [lufe_pkg::LW-1:0] rb;
    logic [lufe_pkg::SIZE_W:0] total;
    ra = find_root(a);
    rb = find_root(b);
    if (ra == rb) return;
    total = {1'b0, class_size[ra]} + {1'b0, class_size[rb]};
    if (total > {1'b0, lufe_pkg::SIZE_MAX}) total = {1'b0, lufe_pkg::SIZE_MAX};
    if (class_size[ra] < class_size[rb]) begin
      link_of[ra] = rb;
      class_size[rb] = total[lufe_pkg::SIZE_W-1:0];
    end else begin
      link_of[rb] = ra;
      class_size[ra] = total[lufe_pkg::SIZE_W-1:0];
    end
  endfunction

  // Effect of one transaction on the shadow; has is set when an answer follows
  function automatic void apply_item(input logic [1:0] act, input logic [lufe_pkg::LW-1:0] la,
                                     input logic [lufe_pkg::LW-1:0] lb, input logic sk,
                                     input logic ls, output bit has, output bit ans);
    bit fits;
    has = 1'b0;
    ans = 1'b0;
    fits = (la < LETTERS) && (lb < LETTERS);
    case (act)
      lufe_pkg::ACT_UNITE: begin
        if (!sk && fits) merge_sets(la, lb);
      end
      lufe_pkg::ACT_QUERY: begin
        if (!sk && (!fits || find_root(la) != find_root(lb))) pairs_agree = 1'b0;
        if (ls) begin
          has = 1'b1;
          ans = pairs_agree;
          pairs_agree = 1'b1;
        end
      end
      lufe_pkg::ACT_MISMATCH: begin
        has = 1'b1;
        pairs_agree = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // Stimulus helpers: class lookup here leaves the shadow untouched
  function automatic logic [lufe_pkg::LW-1:0] peek_root(input logic [lufe_pkg::LW-1:0] x);
    for (int n = 0; n < LETTERS; n++) begin
      if (link_of[x] == x) break;
      x = link_of[x];
    end
    return x;
  endfunction

  function automatic logic [lufe_pkg::LW-1:0] pick_letter();
    if ($urandom_range(0, 32) == 0) return lufe_pkg::LW'($urandom_range(LETTERS, 31));
    return lufe_pkg::LW'($urandom_range(0, LETTERS - 1));
  endfunction

  function automatic logic [lufe_pkg::LW-1:0] class_mate(input logic [lufe_pkg::LW-1:0] a);
    logic [lufe_pkg::LW-1:0] mates [$];
    logic [lufe_pkg::LW-1:0] ra;
    if (a >= LETTERS) return a;
    ra = peek_root(a);
    for (int i = 0; i < LETTERS; i++)
      if (peek_root(i[lufe_pkg::LW-1:0]) == ra) mates.push_back(i[lufe_pkg::LW-1:0]);
    return mates[$urandom_range(0, mates.size() - 1)];
  endfunction

  function automatic int gap_len(input bit no_gaps);
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Present one transaction and hold it until the block takes it
  task automatic send_item(input logic [1:0] act, input logic [lufe_pkg::LW-1:0] la,
                           input logic [lufe_pkg::LW-1:0] lb, input logic sk, input logic ls,
                           input bit typed, input bit typed_ans);
    bit has;
    bit ans;
    action <= act;
    letter_a <= la;
    letter_b <= lb;
    skip <= sk;
    last <= ls;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_item(act, la, lb, sk, ls, has, ans);
    if (typed) ans = typed_ans;
    if (has) begin
      answers_due.push_back(ans);
      if (ans) yes_due++;
      else no_due++;
    end
    if (act == ACT_UNUSED) noise_sent++;
    else items_sent++;
    if (act == lufe_pkg::ACT_UNITE) unites_sent++;
  endtask

  task automatic rest(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_answers();
    start <= 1'b0;
    do @(posedge clk); while (answers_due.size() != 0);
  endtask

  // Result checker and watchdog
  int idle_cycles = 0;
  always @(posedge clk) begin
    bit want;
    if (!rst) begin
      if ((start && !busy) || done) idle_cycles = 0;
      else idle_cycles++;
      if (done) begin
        if (answers_due.size() == 0) begin
          if (mismatches < 10) $display("answer %0b with no query outstanding", answer);
          mismatches++;
        end else begin
          want = answers_due.pop_front();
          if (answer !== want) begin
            if (mismatches < 10) $display("answer mismatch: expected %0b, got %0b", want, answer);
            mismatches++;
          end
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d answers pending",
                 STALL_LIMIT, answers_due.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    int base;
    int qlen;
    int roll;
    bit no_gaps;
    bit drained;
    logic [lufe_pkg::LW-1:0] la;
    logic [lufe_pkg::LW-1:0] lb;
    clear_sets();
    drained = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (DIR_ROWS[i]) begin
      send_item(DIR_ROWS[i].act, DIR_ROWS[i].a, DIR_ROWS[i].b, DIR_ROWS[i].sk,
                DIR_ROWS[i].ls, DIR_ROWS[i].typed, DIR_ROWS[i].ans);
      rest(gap_len(1'b0));
    end

    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      // every fourth stretch runs back to back
      no_gaps = ((items_sent - base) / 150) % 4 == 3;
      if (!drained && items_sent - base >= DRAIN_AT) begin
        drain_answers();
        drained = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        send_item(lufe_pkg::ACT_UNITE, pick_letter(), pick_letter(),
                  $urandom_range(0, 19) == 0, 1'($urandom_range(0, 1)), 1'b0, 1'b0);
        rest(gap_len(no_gaps));
      end else if (roll < 8) begin
        send_item(ACT_UNUSED, lufe_pkg::LW'($urandom_range(0, 31)),
                  lufe_pkg::LW'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'b0, 1'b0);
        rest(gap_len(no_gaps));
      end else if (roll < 13) begin
        send_item(lufe_pkg::ACT_MISMATCH, lufe_pkg::LW'($urandom_range(0, 31)),
                  lufe_pkg::LW'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'b0, 1'b0);
        rest(gap_len(no_gaps));
      end else begin
        // a query word pair, most pairs drawn from one class
        qlen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
        for (int i = 0; i < qlen; i++) begin
          if (i > 0 && $urandom_range(0, 24) == 0) begin
            send_item(lufe_pkg::ACT_MISMATCH, pick_letter(), pick_letter(), 1'b0, 1'b0,
                      1'b0, 1'b0);
            rest(gap_len(no_gaps));
            break;
          end
          la = pick_letter();
          lb = ($urandom_range(0, 99) < 65) ? class_mate(la) : pick_letter();
          send_item(lufe_pkg::ACT_QUERY, la, lb, $urandom_range(0, 9) == 0, i == qlen - 1,
                    1'b0, 1'b0);
          rest(gap_len(no_gaps));
        end
      end
    end

    // let the last answers arrive, then watch for stray ones
    drain_answers();
    repeat (40) @(posedge clk);
    if (answers_due.size() != 0) begin
      $display("%0d answers never arrived", answers_due.size());
      mismatches++;
    end
    $display("Ran %0d transactions (%0d unites, %0d ignored codes)",
             items_sent + noise_sent, unites_sent, noise_sent);
    $display("Checked %0d answers: %0d yes, %0d no", yes_due + no_due, yes_due, no_due);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
